// File: hw/rtl/tcst_pkg.sv
package tcst_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int KEY_W      = 64;

  localparam logic [SLOT_W:0]   SLOT_CNT_C  = (SLOT_W + 1)'(SLOT_COUNT);
  localparam logic [SLOT_W-1:0] SLOT_LAST_C = SLOT_W'(SLOT_COUNT - 1);

  localparam logic [1:0] EV_DOWN   = 2'd0;
  localparam logic [1:0] EV_MOTION = 2'd1;
  localparam logic [1:0] EV_UP     = 2'd2;
  localparam logic [1:0] EV_CANCEL = 2'd3;

  typedef struct packed {
    logic [1:0]       event_kind;
    logic [KEY_W-1:0] touch_device_id;
    logic [KEY_W-1:0] finger_key;
  } tcst_in_t;

  typedef struct packed {
    logic [3:0] slot_index;
    logic [1:0] touch_phase;
  } tcst_out_t;

  typedef struct packed {
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [2*KEY_W-1:0] wr_key;
  } tcst_mem_req_t;

  // low four bits of a slot number
  function automatic logic [3:0] slot_to_index(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+3:0] ext;
    ext = {4'b0000, s};
    return ext[3:0];
  endfunction

endpackage

// File: hw/rtl/tcst_key_mem.sv
module tcst_key_mem
  import tcst_pkg::*;
(
  input  logic                 clk,
  input  tcst_mem_req_t        req,
  output logic [2*KEY_W-1:0]   rd_key
);

  logic [2*KEY_W-1:0] mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_key <= mem[req.rd_addr];
    end
  end

endmodule

// File: hw/rtl/tcst_engine.sv
module tcst_engine
  import tcst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               enable,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcst_in_t           in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tcst_out_t          out_item,
  output tcst_mem_req_t      mem_req,
  input  logic [2*KEY_W-1:0] rd_key
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state;
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [1:0]            kind;
  logic [2*KEY_W-1:0]    key;
  logic [SLOT_W:0]       iss;
  logic                  pend;
  logic [SLOT_W-1:0]     pidx;
  logic                  hit;
  logic [SLOT_W-1:0]     slot_sel;

  logic                  accept;
  logic                  issue;
  logic                  cmp_hit;
  logic                  free_any;
  logic [SLOT_W-1:0]     free_lo;
  logic                  out_free;
  logic                  ended;
  logic                  emit;
  logic [SLOT_W-1:0]     slot_res;

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_lo  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_any = 1'b1;
        free_lo  = SLOT_W'(i);
      end
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign issue    = (state == ST_SCAN) && (iss < SLOT_CNT_C);
  assign cmp_hit  = pend && slot_valid[pidx] && (rd_key == key);
  assign out_free = !out_valid || !out_stall;
  assign ended    = (kind == EV_UP) || (kind == EV_CANCEL);
  assign slot_res = hit ? slot_sel : free_lo;
  assign emit     = (state == ST_DONE) && (hit || free_any) && out_free;

  assign mem_req.rd_en   = issue;
  assign mem_req.rd_addr = iss[SLOT_W-1:0];
  assign mem_req.wr_en   = emit && !hit;
  assign mem_req.wr_addr = free_lo;
  assign mem_req.wr_key  = key;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      pend       <= 1'b0;
      hit        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && enable) begin
            kind  <= in_item.event_kind;
            key   <= {in_item.touch_device_id, in_item.finger_key};
            iss   <= '0;
            pend  <= 1'b0;
            hit   <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            iss <= iss + 1'b1;
          end
          pidx <= iss[SLOT_W-1:0];
          if (cmp_hit) begin
            hit      <= 1'b1;
            slot_sel <= pidx;
            pend     <= 1'b0;
            state    <= ST_DONE;
          end else if (pend && (pidx == SLOT_LAST_C)) begin
            pend  <= 1'b0;
            state <= ST_DONE;
          end else begin
            pend <= issue;
          end
        end
        ST_DONE: begin
          if (!hit && !free_any) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_item.slot_index  <= slot_to_index(slot_res);
            out_item.touch_phase <= kind;
            slot_valid[slot_res] <= !ended;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend)
    else $error("compare pending while idle");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && hit) |-> slot_valid[slot_sel])
    else $error("matched slot is not valid");

  a_end_frees: assert property (@(posedge clk) disable iff (rst)
    (emit && ended) |=> !slot_valid[$past(slot_res)])
    else $error("ended contact left slot valid");

  a_claim_sets: assert property (@(posedge clk) disable iff (rst)
    (emit && !ended) |=> slot_valid[$past(slot_res)] && out_valid)
    else $error("active contact slot not marked valid");

  a_no_write_on_hit: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> (state == ST_DONE) && !slot_valid[mem_req.wr_addr])
    else $error("key write to a live slot");
`endif

endmodule

// File: hw/rtl/touch_contact_slot_tracker_unit.sv
// Touch contact slot tracker.
// Input channel (in_valid / in_stall / in_item): one touch event per item,
// carrying the event kind, device id and finger id. The block takes one
// event at a time; in_stall stays high while an event is being resolved.
// Output channel (out_valid / out_stall / out_item): zero or one item per
// event, giving the slot index and touch phase. No item is produced when
// input_enable is zero or when the table is full with no matching slot.
// The sweep through the key memory (one slot per cycle) runs to the last
// slot when no slot matches; a match at slot k ends it early.
// Disabled events are dropped on acceptance.
// Result is held in an output register; a new event is accepted while it
// waits. If the receiver stalls and the next result is ready, the block
// holds it until the output register frees.
// Reset (rst, synchronous) clears all slot valid marks and sets
// input_enable to 1. Key storage is not cleared.
// APB register at byte address 0: bit 0 is input_enable.
module touch_contact_slot_tracker_unit
  import tcst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  tcst_in_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output tcst_out_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ADDR_INPUT_ENABLE = 3'd0;

  logic               input_enable;
  tcst_mem_req_t      mem_req;
  logic [2*KEY_W-1:0] rd_key;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_INPUT_ENABLE) ? {31'b0, input_enable} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_INPUT_ENABLE)) begin
      input_enable <= pwdata[0];
    end
  end

  tcst_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .enable    (input_enable),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .mem_req   (mem_req),
    .rd_key    (rd_key)
  );

  tcst_key_mem u_key_mem (
    .clk    (clk),
    .req    (mem_req),
    .rd_key (rd_key)
  );

endmodule

// File: test/touch_contact_slot_tracker_unit_tb.sv
module touch_contact_slot_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcst_pkg::*;

  localparam logic [2:0] REG_INPUT_ENABLE = 3'd0;
  localparam int SETTLE_CYCLES  = 24;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;

  typedef enum logic {ROW_EVENT, ROW_ENABLE} row_op_t;

  typedef struct {
    row_op_t          op;
    logic [1:0]       kind;
    logic [KEY_W-1:0] dev;
    logic [KEY_W-1:0] fin;
    bit               typed;
    bit               yields;
    logic [3:0]       slot;
    bit               enable;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  tcst_in_t    in_item;
  logic        out_valid;
  logic        out_stall = 1'b0;
  tcst_out_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the contact table
  bit               contact_live [SLOT_COUNT];
  logic [KEY_W-1:0] contact_dev  [SLOT_COUNT];
  logic [KEY_W-1:0] contact_fin  [SLOT_COUNT];
  bit               intake_enabled;

  tcst_out_t        slot_reports_due[$];
  script_row_t      script[$];
  logic [KEY_W-1:0] dev_pool [4];
  logic [KEY_W-1:0] fin_pool [6];

  int mismatch_count = 0;
  int idle_cycles    = 0;
  int src_idle_pct   = 14;
  int rcv_idle_pct   = 52;
  bit hold_start     = 1'b0;
  bit hold_taken     = 1'b0;
  int hold_left      = 0;

  touch_contact_slot_tracker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  function automatic void queue_report(input tcst_out_t rep);
    slot_reports_due = {slot_reports_due, rep};
  endfunction

  // match first, else claim lowest free slot; up/cancel frees it afterwards
  function automatic void resolve_contact(input tcst_in_t ev, output bit hit,
                                          output tcst_out_t res);
    int s;
    int i;
    hit = 1'b0;
    res = '0;
    s = -1;
    if (!intake_enabled) return;
    for (i = 0; i < SLOT_COUNT; i++) begin
      if (s < 0 && contact_live[i] && contact_dev[i] == ev.touch_device_id &&
          contact_fin[i] == ev.finger_key) begin
        s = i;
      end
    end
    for (i = 0; i < SLOT_COUNT; i++) begin
      if (s < 0 && !contact_live[i]) begin
        s = i;
        contact_dev[i]  = ev.touch_device_id;
        contact_fin[i]  = ev.finger_key;
        contact_live[i] = 1'b1;
      end
    end
    if (s < 0) return;
    hit = 1'b1;
    res.slot_index  = s[3:0];
    res.touch_phase = ev.event_kind;
    if (ev.event_kind == EV_UP || ev.event_kind == EV_CANCEL) begin
      contact_live[s] = 1'b0;
    end
  endfunction

  task automatic predict_and_queue(input tcst_in_t ev);
    bit        hit;
    tcst_out_t res;
    resolve_contact(ev, hit, res);
    if (hit) queue_report(res);
  endtask

  // mostly well-formed touch sequences on a small key pool, plus noise
  function automatic tcst_in_t make_event();
    tcst_in_t ev;
    int       pick;
    int       s;
    int       live_slots[$];
    for (s = 0; s < SLOT_COUNT; s++) begin
      if (contact_live[s]) live_slots = {live_slots, s};
    end
    pick = $urandom_range(99);
    ev.event_kind      = EV_DOWN;
    ev.touch_device_id = dev_pool[$urandom_range(3)];
    ev.finger_key      = fin_pool[$urandom_range(5)];
    if (pick < 8) begin
      ev.event_kind      = 2'($urandom_range(3));
      ev.touch_device_id = {$urandom, $urandom};
      ev.finger_key      = {$urandom, $urandom};
    end else if (pick < 20) begin
      ev.event_kind = 2'($urandom_range(3));
    end else if (pick >= 45 && live_slots.size() != 0) begin
      s = live_slots[$urandom_range(live_slots.size() - 1)];
      ev.touch_device_id = contact_dev[s];
      ev.finger_key      = contact_fin[s];
      if (pick < 75) ev.event_kind = EV_MOTION;
      else if (pick < 88) ev.event_kind = EV_UP;
      else ev.event_kind = EV_CANCEL;
    end
    return ev;
  endfunction

  // called and returns at a falling edge
  task automatic push_event(input tcst_in_t ev);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_enable(input bit value);
    in_valid <= 1'b0;
    while (slot_reports_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_INPUT_ENABLE;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    intake_enabled = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== value) begin
      flag_mismatch($sformatf("input_enable reads %0b, expected %0b", prdata[0], value));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random(input int count);
    tcst_in_t ev;
    repeat (count) begin
      ev = make_event();
      push_event(ev);
      predict_and_queue(ev);
    end
  endtask

  function automatic void ev_row(input logic [1:0] kind, input logic [KEY_W-1:0] dev,
                                 input logic [KEY_W-1:0] fin, input bit typed,
                                 input bit yields, input logic [3:0] slot);
    script_row_t row;
    row = '{ROW_EVENT, kind, dev, fin, typed, yields, slot, 1'b0};
    script = {script, row};
  endfunction

  function automatic void cfg_row(input bit value);
    script_row_t row;
    row = '{ROW_ENABLE, EV_DOWN, '0, '0, 1'b0, 1'b0, 4'd0, value};
    script = {script, row};
  endfunction

  // receiver side
  always @(negedge clk) begin
    if (hold_start && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_reports
    tcst_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (slot_reports_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected item slot %0d phase %0d",
                                out_item.slot_index, out_item.touch_phase));
      end else begin
        want = slot_reports_due.pop_front();
        if (out_item.slot_index !== want.slot_index ||
            out_item.touch_phase !== want.touch_phase) begin
          flag_mismatch($sformatf("slot %0d phase %0d, expected slot %0d phase %0d",
                                  out_item.slot_index, out_item.touch_phase,
                                  want.slot_index, want.touch_phase));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tcst_in_t  ev;
    bit        hit;
    tcst_out_t res;
    int        j;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_item  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    intake_enabled = 1'b1;
    for (j = 0; j < SLOT_COUNT; j++) contact_live[j] = 1'b0;
    dev_pool[0] = '0;
    dev_pool[1] = KEY_ONES;
    dev_pool[2] = {$urandom, $urandom};
    dev_pool[3] = {$urandom, $urandom};
    fin_pool[0] = '0;
    fin_pool[1] = KEY_ONES;
    for (j = 2; j < 6; j++) fin_pool[j] = {$urandom, $urandom};

    ev_row(EV_DOWN,   '0,       '0,       1, 1, 4'd0);
    ev_row(EV_DOWN,   KEY_ONES, KEY_ONES, 1, 1, 4'd1);
    ev_row(EV_MOTION, KEY_ONES, KEY_ONES, 1, 1, 4'd1);
    ev_row(EV_UP,     '0,       '0,       1, 1, 4'd0);
    // unmatched cancel claims slot 0 and frees it again
    ev_row(EV_CANCEL, '0,       KEY_ONES, 1, 1, 4'd0);
    for (j = 0; j < 15; j++) begin
      ev_row(EV_DOWN, {8'(j + 1), 48'h0, 8'(j + 1)}, ~{8'(j + 1), 48'h0, 8'(j + 1)},
             1, 1, (j == 0) ? 4'd0 : 4'(j + 1));
    end
    // table full
    ev_row(EV_DOWN,   64'h5a5a_5a5a_a5a5_a5a5, '0, 1, 0, 4'd0);
    ev_row(EV_MOTION, {8'd9, 48'h0, 8'd9}, ~{8'd9, 48'h0, 8'd9}, 1, 1, 4'd9);
    ev_row(EV_CANCEL, KEY_ONES, KEY_ONES, 1, 1, 4'd1);
    cfg_row(1'b0);
    ev_row(EV_DOWN,   '0, '0, 1, 0, 4'd0);
    cfg_row(1'b1);
    ev_row(EV_MOTION, KEY_ONES, '0, 0, 0, 4'd0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[r]) begin
      if (script[r].op == ROW_ENABLE) begin
        set_enable(script[r].enable);
      end else begin
        ev.event_kind      = script[r].kind;
        ev.touch_device_id = script[r].dev;
        ev.finger_key      = script[r].fin;
        push_event(ev);
        resolve_contact(ev, hit, res);
        if (script[r].typed) begin
          if (script[r].yields) queue_report('{script[r].slot, script[r].kind});
        end else if (hit) begin
          queue_report(res);
        end
      end
    end

    run_random(580);
    set_enable(1'b0);
    run_random(25);
    set_enable(1'b1);

    src_idle_pct = 52;
    rcv_idle_pct = 14;
    run_random(580);
    set_enable(1'b0);
    run_random(10);
    set_enable(1'b1);

    src_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_start   = 1'b1;
    run_random(580);

    in_valid <= 1'b0;
    while (slot_reports_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
